>>> rtl/dat_pkg.sv
// ----------------------------------------------------------------------------
// dat_pkg: shared types and constants of the delayed-ACK timer table
// Field widths, register indexes, channel payloads and control structs.
// ----------------------------------------------------------------------------
package dat_pkg;

  localparam int SID_W     = 10;
  localparam int TYPE_W    = 4;
  localparam int PAY_W     = 64;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_SESSIONS     = 1024;
  localparam int DEF_COUNTER_BITS = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ACK_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE  = 1'd1;

  localparam logic [CFG_W-1:0]  ACK_DELAY_RST = 12'd64;
  localparam logic [TYPE_W-1:0] ACK_TYPE_RST  = 4'd0;

  typedef struct packed {
    logic              action;
    logic [TYPE_W-1:0] event_type;
    logic [SID_W-1:0]  session_id;
    logic [PAY_W-1:0]  event_payload;
    logic              downstream_full;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0] out_type;
    logic [SID_W-1:0]  out_session;
    logic [PAY_W-1:0]  out_payload;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic mem_read;
    logic update;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_block;
  } dp_sts_t;

endpackage

>>> rtl/dat_stream_if.sv
// ----------------------------------------------------------------------------
// dat_stream_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface dat_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/delayed_ack_timer_table.sv
// ----------------------------------------------------------------------------
// delayed_ack_timer_table: per-session delayed-ACK timers
// Holds back first ACKs per session and regenerates them after a tick delay.
// ----------------------------------------------------------------------------
// One down-counter per session sits in a single-port-each-way memory with a
// registered read. After reset the block sweeps the memory to zero, one entry
// a cycle, and takes no transaction meanwhile (register writes are taken as
// usual). Each input transaction then goes through capture, memory read and
// update/write. A table smaller than the id space maps the session id to its
// slot with a reciprocal multiply at capture and a multiply-subtract ahead of
// the read, so this adds no step. The memory port and the read-modify-write
// of one counter set these steps. The result goes to an output register, so
// a new transaction is taken while the last result still waits; the update
// stalls only if it must emit and that register is still occupied. Register
// writes must happen while no transaction is in flight.
module delayed_ack_timer_table #(
  parameter int SESSIONS     = dat_pkg::DEF_SESSIONS,
  parameter int COUNTER_BITS = dat_pkg::DEF_COUNTER_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dat_pkg::CFG_W-1:0]     cfg_data_i,
  dat_stream_if.sink                    in_i,
  dat_stream_if.source                  out_o
);
  import dat_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: clear sweep, then one transaction at a time
  dat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, pointer, slot mapping and output register
  dat_datapath #(
    .SESSIONS     (SESSIONS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

endmodule

>>> rtl/dat_ctrl.sv
// ----------------------------------------------------------------------------
// dat_ctrl: sequencing of the timer table
// Clear sweep after reset, then capture / read / update per item.
// ----------------------------------------------------------------------------
module dat_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dat_pkg::dp_sts_t sts_i,
  output dat_pkg::dp_cmd_t cmd_o
);
  import dat_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = ST_CALC;
      end
      ST_CALC: begin
        if (!sts_i.out_block) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/dat_datapath.sv
// ----------------------------------------------------------------------------
// dat_datapath: counter memory, slot reduction, scan pointer, output register
// Executes the commands of dat_ctrl and reports status back.
// ----------------------------------------------------------------------------
module dat_datapath #(
  parameter int SESSIONS     = dat_pkg::DEF_SESSIONS,
  parameter int COUNTER_BITS = dat_pkg::DEF_COUNTER_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dat_pkg::CFG_W-1:0]     cfg_data_i,
  input  dat_pkg::in_item_t             in_data_i,
  input  dat_pkg::dp_cmd_t              cmd_i,
  output dat_pkg::dp_sts_t              sts_o,
  dat_stream_if.source                  out_o
);
  import dat_pkg::*;

  localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int CNT_W = COUNTER_BITS;
  // session_id modulo SESSIONS: quotient by reciprocal multiply, exact for
  // every id of SID_W bits; a table as large as the id space uses the id
  localparam bit WHOLE_ID = (SESSIONS >= (1 << SID_W));
  localparam int RCP_SH   = SID_W + IDX_W;
  localparam int RCP_W    = SID_W + 2;
  localparam logic [RCP_W-1:0] RCP_MUL = RCP_W'(((1 << RCP_SH) + SESSIONS - 1) / SESSIONS);
  localparam logic [SID_W-1:0] SESS_C  = SID_W'(SESSIONS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSIONS - 1);

  // configuration
  logic [CFG_W-1:0]  delay_q;
  logic [TYPE_W-1:0] code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= ACK_DELAY_RST;
      code_q  <= ACK_TYPE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACK_DELAY: delay_q <= cfg_data_i;
        REG_ACK_TYPE:  code_q  <= cfg_data_i[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item and slot reduction
  logic                   act_q, full_q;
  logic [TYPE_W-1:0]      type_q;
  logic [SID_W-1:0]       sid_q, quot_q, quot_d;
  logic [PAY_W-1:0]       pay_q;
  logic [SID_W+RCP_W-1:0] quot_prod;
  logic [SID_W-1:0]       slot;

  assign quot_prod = in_data_i.session_id * RCP_MUL;
  assign quot_d    = SID_W'(quot_prod >> RCP_SH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= in_data_i.action;
      full_q <= in_data_i.downstream_full;
      type_q <= in_data_i.event_type;
      sid_q  <= in_data_i.session_id;
      pay_q  <= in_data_i.event_payload;
      quot_q <= quot_d;
    end
  end

  assign slot = WHOLE_ID ? sid_q : sid_q - SID_W'(quot_q * SESS_C);

  // scan pointer and clear sweep index
  logic [IDX_W-1:0] ptr_q, clr_q;
  logic [IDX_W-1:0] addr;

  assign addr = act_q ? ptr_q : IDX_W'(slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clear_step) clr_q <= (clr_q == LAST_IDX) ? '0 : clr_q + 1'b1;
      if (cmd_i.update && act_q) ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
    end
  end

  // counter memory, one port each way, registered read
  logic [CNT_W-1:0] mem [SESSIONS];
  logic [CNT_W-1:0] rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CNT_W-1:0] mem_wdata;

  // update decision
  logic             wr_en, emit;
  logic [CNT_W-1:0] wr_val;
  out_item_t        emit_data;

  always_comb begin
    wr_en     = 1'b0;
    wr_val    = '0;
    emit      = 1'b0;
    emit_data = '0;
    if (act_q) begin
      if (rd_q != '0 && !full_q) begin
        wr_en  = 1'b1;
        wr_val = rd_q - 1'b1;
        if (rd_q == CNT_W'(1)) begin
          emit                  = 1'b1;
          emit_data.out_type    = code_q;
          emit_data.out_session = SID_W'(ptr_q);
        end
      end
    end else if (type_q == code_q && rd_q == '0) begin
      wr_en  = 1'b1;
      wr_val = CNT_W'(delay_q);
    end else begin
      wr_en                 = 1'b1;
      emit                  = 1'b1;
      emit_data.out_type    = type_q;
      emit_data.out_session = sid_q;
      emit_data.out_payload = pay_q;
    end
  end

  assign mem_we    = cmd_i.clear_step | (cmd_i.update & wr_en);
  assign mem_waddr = cmd_i.clear_step ? clr_q : addr;
  assign mem_wdata = cmd_i.clear_step ? '0 : wr_val;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.mem_read) rd_q <= mem[addr];
  end

  // output register
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && emit) out_data_q <= emit_data;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign sts_o.clear_done = (clr_q == LAST_IDX);
  assign sts_o.out_block  = emit && out_valid_q && !out_o.ready;

endmodule

>>> rtl/dat_checker.sv
// ----------------------------------------------------------------------------
// dat_checker: port-level checks of the timer table
// Handshake and sequencing properties seen on the top-level channels.
// ----------------------------------------------------------------------------
module dat_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input dat_pkg::out_item_t out_data_i
);
  import dat_pkg::*;

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // every transaction keeps the input closed through its read and update steps
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("input taken during read-modify-write");

  // a new result only appears from an update, never straight from idle
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without an update cycle");

endmodule

bind delayed_ack_timer_table dat_checker u_dat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

>>> dv/dat_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dat_tb_pkg: scoreboard for the delayed-ACK timer table
// Tracks per-session timers and the scan pointer, and checks emitted
// transactions in order.
// ----------------------------------------------------------------------------
package dat_tb_pkg;

  import dat_pkg::*;

  localparam int NUM_SESS = DEF_SESSIONS;
  localparam int CNT_W    = DEF_COUNTER_BITS;

  class ack_timer_scoreboard;
    logic [CNT_W-1:0]  timer [NUM_SESS];
    logic [SID_W-1:0]  scan_ptr;
    logic [CFG_W-1:0]  hold_ticks;
    logic [TYPE_W-1:0] ack_type;
    out_item_t         emitted_q [$];
    int errors, n_events, n_ticks, n_held, n_fwd;
    int n_gen, n_skipped, n_wraps, n_checked;

    function new();
      foreach (timer[i]) timer[i] = '0;
      scan_ptr   = '0;
      hold_ticks = ACK_DELAY_RST;
      ack_type   = ACK_TYPE_RST;
      errors     = 0;
      n_events   = 0;
      n_ticks    = 0;
      n_held     = 0;
      n_fwd      = 0;
      n_gen      = 0;
      n_skipped  = 0;
      n_wraps    = 0;
      n_checked  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_ACK_DELAY: hold_ticks = val;
        REG_ACK_TYPE:  ack_type   = val[TYPE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return emitted_q.size();
    endfunction

    function void note_input(in_item_t it);
      out_item_t        res;
      logic [SID_W-1:0] slot;
      if (!it.action) begin
        n_events++;
        // table depth equals the id space, so the slot is the id itself
        slot = it.session_id;
        if (it.event_type == ack_type && timer[slot] == '0) begin
          timer[slot] = hold_ticks[CNT_W-1:0];
          n_held++;
        end else begin
          timer[slot]     = '0;
          res.out_type    = it.event_type;
          res.out_session = it.session_id;
          res.out_payload = it.event_payload;
          emitted_q.push_back(res);
          n_fwd++;
        end
      end else begin
        n_ticks++;
        if (timer[scan_ptr] != '0) begin
          if (it.downstream_full) begin
            n_skipped++;
          end else begin
            if (timer[scan_ptr] == CNT_W'(1)) begin
              res.out_type    = ack_type;
              res.out_session = scan_ptr;
              res.out_payload = '0;
              emitted_q.push_back(res);
              n_gen++;
            end
            timer[scan_ptr] = timer[scan_ptr] - 1'b1;
          end
        end
        if (scan_ptr == SID_W'(NUM_SESS - 1)) n_wraps++;
        scan_ptr = scan_ptr + 1'b1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      n_checked++;
      if (emitted_q.size() == 0) begin
        $display("%0t: unexpected result: type %0d session %0d payload %h",
                 $time, got.out_type, got.out_session, got.out_payload);
        errors++;
        return;
      end
      want = emitted_q.pop_front();
      if (got.out_type !== want.out_type) begin
        $display("%0t: out_type mismatch: expected %0d, actual %0d",
                 $time, want.out_type, got.out_type);
        errors++;
      end
      if (got.out_session !== want.out_session) begin
        $display("%0t: out_session mismatch: expected %0d, actual %0d",
                 $time, want.out_session, got.out_session);
        errors++;
      end
      if (got.out_payload !== want.out_payload) begin
        $display("%0t: out_payload mismatch: expected %h, actual %h",
                 $time, want.out_payload, got.out_payload);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the delayed-ACK timer table
// Drives events and scan ticks over valid/ready channels, rewrites the delay
// and ACK code between phases, and checks every emitted transaction against
// a scoreboard that tracks per-session timers and the scan pointer.
// ----------------------------------------------------------------------------
module tb;

  import dat_pkg::*;
  import dat_tb_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  dat_stream_if #(.T(in_item_t))  in_ch ();
  dat_stream_if #(.T(out_item_t)) out_ch ();

  delayed_ack_timer_table u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  ack_timer_scoreboard sb;

  bit calm;      // no idling on either side once set
  int hold_len;  // long output stall requested by the main sequence

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor. Values read right after the edge are the ones the edge sampled,
  // since every driver and the DUT update through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  // Output side: mostly ready, random stall bursts, and one long hold-off
  // so that the output register fills and the block backs up its input.
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Random item. Most events land just ahead of the scan pointer and half of
  // them carry the ACK code, so held ACKs actually time out under ticks
  // instead of waiting a full sweep.
  function automatic in_item_t rand_item(int tick_pct);
    in_item_t it;
    int       r;
    it.action          = ($urandom_range(0, 99) < tick_pct);
    it.downstream_full = ($urandom_range(0, 3) == 0);
    it.event_type      = $urandom_range(0, 1) ? sb.ack_type : TYPE_W'($urandom);
    if ($urandom_range(0, 3) != 0) it.session_id = sb.scan_ptr + SID_W'($urandom_range(0, 6));
    else it.session_id = SID_W'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) it.event_payload = '0;
    else if (r == 1) it.event_payload = '1;
    else it.event_payload = {$urandom, $urandom};
    return it;
  endfunction

  // One input transaction; valid stays high into the next item unless a gap
  // is drawn.
  task automatic push_item(input in_item_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_event(input logic [TYPE_W-1:0] ty, input logic [SID_W-1:0] sid,
                            input logic [PAY_W-1:0] pay, input logic full = 1'b0);
    in_item_t it;
    it.action          = 1'b0;
    it.event_type      = ty;
    it.session_id      = sid;
    it.event_payload   = pay;
    it.downstream_full = full;
    push_item(it);
  endtask

  task automatic send_tick(input logic full);
    in_item_t it;
    it                 = rand_item(100);
    it.downstream_full = full;
    push_item(it);
  endtask

  task automatic run_random(input int n, input int tick_pct);
    repeat (n) push_item(rand_item(tick_pct));
  endtask

  // Drain: input idle, every expected result seen, then a wait for a
  // transaction that emits nothing to leave the pipeline.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Both registers back to back; enable stays high across the two writes.
  task automatic configure(input logic [CFG_W-1:0] delay, input logic [TYPE_W-1:0] ty);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ACK_DELAY;
    cfg_data <= delay;
    @(posedge clk);
    sb.write_reg(REG_ACK_DELAY, delay);
    cfg_idx  <= REG_ACK_TYPE;
    cfg_data <= CFG_W'(ty);
    @(posedge clk);
    sb.write_reg(REG_ACK_TYPE, CFG_W'(ty));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [SID_W-1:0] base;
    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    calm        = 1'b0;
    hold_len    = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (delay 64, ACK code 0). The block clears its table
    // first, so the first transaction waits out that pass.
    send_event(4'hF, 10'h3FF, '1);
    send_event(4'h1, 10'h000, '0, 1'b1);              // full flag ignored on events
    send_event(ACK_TYPE_RST, 10'd5, {$urandom, $urandom});  // first ACK is held
    send_event(ACK_TYPE_RST, 10'd5, {$urandom, $urandom});  // second ACK forwarded
    send_event(ACK_TYPE_RST, 10'd6, {$urandom, $urandom});
    send_event(4'h9, 10'd6, {$urandom, $urandom});     // other event cancels the hold
    send_event(ACK_TYPE_RST, 10'h3FF, '1);             // stays held, pointer never gets there
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // Shortest delay, top ACK code: a held ACK comes back on the next visit.
    configure(12'd1, 4'hF);
    base = sb.scan_ptr;
    send_event(4'hF, base + 1'b1, {$urandom, $urandom});
    send_tick(1'b0);
    send_tick(1'b0);                                   // visits base+1, emits
    send_event(4'hF, base + 10'd2, '1);
    send_tick(1'b1);                                   // full output: no decrement
    send_event(4'h3, base + 10'd2, '0);                // still pending, so forwarded
    run_random(120, 50);
    settle();

    // Zero delay: an ACK at an idle session is swallowed for good.
    configure(12'd0, 4'd7);
    send_event(4'd7, sb.scan_ptr, {$urandom, $urandom});
    send_tick(1'b0);
    run_random(60, 40);
    settle();

    // Delay 2: held ACKs just ahead of the pointer drop to 1 on their visit
    // and stay pending; a second ACK on one of them is forwarded.
    configure(12'd2, 4'($urandom_range(0, 15)));
    base = sb.scan_ptr;
    for (int k = 1; k <= 4; k++) begin
      send_event(sb.ack_type, base + SID_W'(k), {$urandom, $urandom});
    end
    send_event(sb.ack_type, 10'h3FF, {$urandom, $urandom});
    repeat (16) send_tick($urandom_range(0, 7) == 0);
    send_event(sb.ack_type, base + 10'd2, {$urandom, $urandom});
    settle();

    // Longest delay, and a long output hold-off while events keep coming.
    configure(12'd4095, 4'd0);
    hold_len = 80;
    run_random(80, 20);
    settle();

    configure(12'($urandom_range(3, 4094)), 4'($urandom_range(1, 14)));
    run_random(60, 40);
    settle();

    // Final stretch at full rate on both sides.
    calm = 1'b1;
    configure(12'd1, 4'($urandom_range(0, 15)));
    run_random(150, 50);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    $display("covered %0d events (%0d ACKs held, %0d forwarded) and %0d scan ticks",
             sb.n_events, sb.n_held, sb.n_fwd, sb.n_ticks);
    $display("%0d ACKs regenerated, %0d ticks blocked by a full output,",
             sb.n_gen, sb.n_skipped);
    $display("%0d pointer wraps, %0d results checked", sb.n_wraps, sb.n_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("%0t: timeout, run did not complete", $time);
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/dat_pkg.sv
rtl/dat_stream_if.sv
rtl/dat_ctrl.sv
rtl/dat_datapath.sv
rtl/delayed_ack_timer_table.sv
rtl/dat_checker.sv
dv/dat_tb_pkg.sv
dv/tb.sv
